[hdl/linked_cell_allocator_unit_macros.svh]
// Assertion macros for the linked cell allocator.
// Included by linked_cell_allocator_unit.sv; expects clk and rst in scope.
`ifndef LINKED_CELL_ALLOCATOR_UNIT_MACROS_SVH
`define LINKED_CELL_ALLOCATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold at every clock edge outside reset.
`define LCA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cond)) \
    else $error(msg);

`endif

[hdl/lca_pkg.sv]
// Shared types and codes for the linked cell allocator.
// No dependencies; used by linked_cell_allocator_unit.sv.
package lca_pkg;

  typedef enum logic [2:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_READ  = 3'd3,
    ACT_QUERY = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_OPEN     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         address;
    logic [63:0]        tag;
    logic signed [31:0] value;
    logic               last_field;
  } in_t;

  typedef struct packed {
    logic [5:0]         handle;
    logic signed [31:0] read_data;
    logic               found;
    logic [6:0]         free_cells;
    logic               cell_is_free;
    logic [1:0]         status;
  } out_t;

endpackage

[hdl/linked_cell_allocator_unit.sv]
// Linked cell allocator: cell memory with a free list threaded through the links.
// Depends on lca_pkg and linked_cell_allocator_unit_macros.svh.
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+-------------------
//   request  | req_valid  | req_stall  | req (lca_pkg::in_t)
//   result   | rsp_valid  | rsp_stall  | rsp (lca_pkg::out_t)
//
// One request at a time; each chain step is one read of the cell memory. Allocate takes the
// head cell of the free list, or skips the read when the list is empty; free, write, read
// and query walk a chain of up to CELLS cells.
// After reset a clearing pass rebuilds the free list before requests go in.
// A result waits in the output register while the next request is taken;
// a request finishing into a full output register holds until it drains.
`include "linked_cell_allocator_unit_macros.svh"

module linked_cell_allocator_unit #(
  parameter int CELLS    = 64,
  parameter int TAG_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lca_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lca_pkg::out_t rsp
);

  localparam int CW = $clog2(CELLS);
  localparam int LW = $clog2(CELLS + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(CELLS);

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic signed [31:0]  value;
    logic [LW-1:0]       link;
  } entry_t;

  entry_t mem [CELLS];
  entry_t rd_q;
  logic          mem_re;
  logic [CW-1:0] mem_raddr;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  entry_t        mem_wdata;

  lca_pkg::state_t state, state_next;
  logic [CW-1:0] clr_idx, clr_idx_next;
  logic [LW-1:0] cur, cur_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [LW-1:0] free_head, free_head_next;
  logic [CW-1:0] alloc_start, alloc_start_next;
  logic          alloc_open, alloc_open_next;
  logic [LW-1:0] free_count, free_count_next;
  lca_pkg::in_t  req_q, req_q_next;
  lca_pkg::out_t res, res_next;
  lca_pkg::out_t rsp_next;
  logic          rsp_valid_next;

  logic [TAG_BITS-1:0] tag_m;
  logic [LW-1:0]       step;
  logic [LW:0]         fc_sum;
  logic                req_addr_ok;

  assign req_stall   = (state != lca_pkg::S_IDLE);
  assign tag_m       = req_q.tag[TAG_BITS-1:0];
  assign step        = cnt + LW'(1);
  assign fc_sum      = {1'b0, free_count} + {1'b0, cnt};
  assign req_addr_ok = 32'(req.address) < 32'(CELLS);

  // cell memory: one write and one registered read, forward a same-cycle write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= (mem_we && mem_waddr == mem_raddr) ? mem_wdata : mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lca_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      free_head   <= '0;
      alloc_start <= '0;
      alloc_open  <= 1'b0;
      free_count  <= LW'(CELLS);
      rsp_valid   <= 1'b0;
    end else begin
      clr_idx     <= clr_idx_next;
      free_head   <= free_head_next;
      alloc_start <= alloc_start_next;
      alloc_open  <= alloc_open_next;
      free_count  <= free_count_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    cnt   <= cnt_next;
    req_q <= req_q_next;
    res   <= res_next;
    rsp   <= rsp_next;
  end

  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    cur_next         = cur;
    cnt_next         = cnt;
    free_head_next   = free_head;
    alloc_start_next = alloc_start;
    alloc_open_next  = alloc_open;
    free_count_next  = free_count;
    req_q_next       = req_q;
    res_next         = res;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && rsp_stall;
    mem_re           = 1'b0;
    mem_raddr        = cur[CW-1:0];
    mem_we           = 1'b0;
    mem_waddr        = cur[CW-1:0];
    mem_wdata        = rd_q;

    unique case (state)
      lca_pkg::S_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clr_idx;
        mem_wdata.tag   = '0;
        mem_wdata.value = '0;
        mem_wdata.link  = LW'(clr_idx) + LW'(1);
        if (clr_idx == CW'(CELLS - 1)) begin
          state_next = lca_pkg::S_IDLE;
        end else begin
          clr_idx_next = clr_idx + CW'(1);
        end
      end

      lca_pkg::S_IDLE: begin
        if (req_valid) begin
          req_q_next = req;
          res_next   = '0;
          state_next = lca_pkg::S_DONE;
          unique case (req.action)
            lca_pkg::ACT_ALLOC: begin
              if (free_head >= NULL_LINK) begin
                res_next.status = lca_pkg::ST_NO_SPACE;
                if (alloc_open) begin
                  res_next.handle = 6'(alloc_start);
                  alloc_open_next = 1'b0;
                end
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = free_head[CW-1:0];
                cur_next   = free_head;
                state_next = lca_pkg::S_WALK;
              end
            end
            lca_pkg::ACT_FREE: begin
              if (req_addr_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = CW'(req.address);
                cur_next   = LW'(req.address);
                cnt_next   = LW'(1);
                state_next = lca_pkg::S_WALK;
              end
            end
            lca_pkg::ACT_WRITE, lca_pkg::ACT_READ: begin
              if (req.action == lca_pkg::ACT_READ) begin
                res_next.read_data = '1;
              end
              if (req_addr_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = CW'(req.address);
                cur_next   = LW'(req.address);
                cnt_next   = '0;
                state_next = lca_pkg::S_WALK;
              end
            end
            lca_pkg::ACT_QUERY: begin
              if (req_addr_ok && free_head < NULL_LINK) begin
                if (free_head == LW'(req.address)) begin
                  res_next.cell_is_free = 1'b1;
                end else begin
                  mem_re     = 1'b1;
                  mem_raddr  = free_head[CW-1:0];
                  cur_next   = free_head;
                  cnt_next   = '0;
                  state_next = lca_pkg::S_WALK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      lca_pkg::S_WALK: begin
        state_next = lca_pkg::S_DONE;
        unique case (req_q.action)
          lca_pkg::ACT_ALLOC: begin
            if (!alloc_open) begin
              alloc_start_next = cur[CW-1:0];
            end
            alloc_open_next = 1'b1;
            mem_we          = 1'b1;
            mem_wdata.tag   = tag_m;
            mem_wdata.link  = req_q.last_field ? NULL_LINK : rd_q.link;
            free_head_next  = rd_q.link;
            if (free_count != '0) begin
              free_count_next = free_count - LW'(1);
            end
            if (req_q.last_field) begin
              res_next.handle = alloc_open ? 6'(alloc_start) : 6'(cur[CW-1:0]);
              alloc_open_next = 1'b0;
            end
          end
          lca_pkg::ACT_FREE: begin
            if (rd_q.link < NULL_LINK && cnt < NULL_LINK) begin
              mem_re     = 1'b1;
              mem_raddr  = rd_q.link[CW-1:0];
              cur_next   = rd_q.link;
              cnt_next   = step;
              state_next = lca_pkg::S_WALK;
            end else begin
              mem_we          = 1'b1;
              mem_wdata.link  = free_head;
              free_head_next  = LW'(req_q.address);
              free_count_next = (fc_sum > (LW + 1)'(CELLS)) ? NULL_LINK : fc_sum[LW-1:0];
            end
          end
          lca_pkg::ACT_WRITE: begin
            if (rd_q.tag == tag_m) begin
              mem_we          = 1'b1;
              mem_wdata.value = req_q.value;
            end
            if (step < NULL_LINK && rd_q.link < NULL_LINK) begin
              mem_re     = 1'b1;
              mem_raddr  = rd_q.link[CW-1:0];
              cur_next   = rd_q.link;
              cnt_next   = step;
              state_next = lca_pkg::S_WALK;
            end
          end
          lca_pkg::ACT_READ: begin
            if (rd_q.tag == tag_m) begin
              res_next.read_data = rd_q.value;
              res_next.found     = 1'b1;
            end else if (step < NULL_LINK && rd_q.link < NULL_LINK) begin
              mem_re     = 1'b1;
              mem_raddr  = rd_q.link[CW-1:0];
              cur_next   = rd_q.link;
              cnt_next   = step;
              state_next = lca_pkg::S_WALK;
            end
          end
          lca_pkg::ACT_QUERY: begin
            if (step < NULL_LINK && rd_q.link < NULL_LINK) begin
              if (rd_q.link == LW'(req_q.address)) begin
                res_next.cell_is_free = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = rd_q.link[CW-1:0];
                cur_next   = rd_q.link;
                cnt_next   = step;
                state_next = lca_pkg::S_WALK;
              end
            end
          end
          default: begin
          end
        endcase
      end

      lca_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next      = 1'b1;
          rsp_next            = res;
          rsp_next.free_cells = 7'(free_count);
          if (res.status != lca_pkg::ST_NO_SPACE) begin
            rsp_next.status = alloc_open ? lca_pkg::ST_OPEN : lca_pkg::ST_OK;
          end
          state_next = lca_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lca_pkg::S_IDLE;
      end
    endcase
  end

  `LCA_ASSERT_ALWAYS(a_free_count_bound, free_count <= NULL_LINK, "free count above CELLS")
  `LCA_ASSERT_ALWAYS(a_free_head_bound, free_head <= NULL_LINK, "free head beyond null link")
  `LCA_ASSERT_IMPLIES(a_walk_bound, state == lca_pkg::S_WALK, cnt <= NULL_LINK, "walk overran")
  `LCA_ASSERT_IMPLIES(a_rsp_from_done, $rose(rsp_valid), $past(state) == lca_pkg::S_DONE, "result without finish")

endmodule
